@@ rtl/sipq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_pkg
// types, sizes and control structs shared by the sorted insert queue
// ----------------------------------------------------------------------------
package sipq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int NODE_BITS   = 16;

	localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = NODE_BITS + 32;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_POP    = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [15:0]        node_id;
		logic signed [31:0] cost;
	} request_t;

	typedef struct packed {
		logic [15:0]        pop_node_id;
		logic signed [31:0] pop_cost;
		logic               pop_valid;
		logic               queue_empty;
		logic [6:0]         queue_count;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] node;
		logic signed [31:0]   cost;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic latch_req;
		logic do_append;
		logic do_clear;
		logic set_ovf;
		logic scan_start;
		logic scan_step;
		logic scan_tail;
		logic pop_take;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_type_t  req_type;
		logic       full;
		logic       empty;
		logic       scan_last;
		logic [CNT_W-1:0] count;
	} dp_status_t;

endpackage

@@ rtl/sorted_insert_priority_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core
// bounded cost-ordered queue with append, sorted insert, pop and clear
// ----------------------------------------------------------------------------
// sequence: append, clear, an empty pop, an insert into an empty queue or a
//   dropped write go from decode to the result; a pop waits for the head read;
//   a sorted insert into a nonempty queue scans every entry, then writes the tail
// handshake: busy is low again in the cycle done is shown, so a new item is
//   taken only once the last is through; the insert scan visits one stored entry
//   per cycle through the single read and single write port of the entry ram
// reset: arst_n clears the count and pointers, the queue comes up empty;
//   entry contents are not cleared; results cannot be stalled by the receiver
module sorted_insert_priority_queue_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sipq_pkg::request_t request,
	output logic               done,
	output sipq_pkg::result_t  result
);

	// command and status between sequencer and datapath
	sipq_pkg::ctrl_cmd_t  cmd;
	sipq_pkg::dp_status_t st;

	// sequencer: decodes the latched request and walks the insert scan
	sipq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.st    (st)
	);

	// datapath: circular entry ram, pointers, count and result registers
	sipq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.st     (st),
		.result (result)
	);

	// an accepted item always makes the block busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// the result strobe only shows while new items may be taken
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a popped entry and a dropped write never come together
	a_pop_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.pop_valid && result.overflow))
		else $error("pop valid and overflow both set");

	// empty flag agrees with the held count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.queue_empty == (st.count == '0)))
		else $error("empty flag disagrees with count");

	// the count never runs past the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.count <= sipq_pkg::CNT_W'(sipq_pkg::QUEUE_DEPTH))
		else $error("count beyond queue depth");

endmodule

@@ rtl/sipq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sipq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sipq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_ctrl
// request sequencer: decode, pop read, insert scan and result strobe
// ----------------------------------------------------------------------------
module sipq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	output sipq_pkg::ctrl_cmd_t  cmd,
	input  sipq_pkg::dp_status_t st
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_SCAN,
		S_TAIL,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE, S_RESP: begin
				if (start) begin
					cmd.latch_req = 1'b1;
					state_d       = S_EXEC;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
				case (st.req_type)
					sipq_pkg::REQ_APPEND: begin
						if (st.full) cmd.set_ovf = 1'b1;
						else cmd.do_append = 1'b1;
					end
					sipq_pkg::REQ_INSERT: begin
						if (st.full) begin
							cmd.set_ovf = 1'b1;
						end else if (st.empty) begin
							cmd.do_append = 1'b1;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					sipq_pkg::REQ_POP: begin
						// head read is issued whenever no scan is stepping, data lands next cycle
						if (!st.empty) state_d = S_POP_WAIT;
					end
					sipq_pkg::REQ_CLEAR: begin
						cmd.do_clear = 1'b1;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_POP_WAIT: begin
				cmd.pop_take = 1'b1;
				state_d      = S_RESP;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) state_d = S_TAIL;
			end
			S_TAIL: begin
				cmd.scan_tail = 1'b1;
				state_d       = S_RESP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE) && (state_d != S_RESP);
			done_q  <= (state_d == S_RESP);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ rtl/sipq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_dp
// circular entry store with head and tail pointers and insert scan datapath
// ----------------------------------------------------------------------------
module sipq_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sipq_pkg::request_t    request,
	input  sipq_pkg::ctrl_cmd_t   cmd,
	output sipq_pkg::dp_status_t  st,
	output sipq_pkg::result_t     result
);

	function automatic logic [sipq_pkg::ADDR_W-1:0] next_ptr(
		input logic [sipq_pkg::ADDR_W-1:0] p
	);
		logic [sipq_pkg::ADDR_W-1:0] n;
		if (p == sipq_pkg::ADDR_W'(sipq_pkg::QUEUE_DEPTH - 1)) n = '0;
		else n = p + 1'b1;
		return n;
	endfunction

	sipq_pkg::request_t           req_q;
	logic [sipq_pkg::ADDR_W-1:0]  head_q;
	logic [sipq_pkg::ADDR_W-1:0]  tail_q;
	logic [sipq_pkg::CNT_W-1:0]   count_q;
	logic [sipq_pkg::ADDR_W-1:0]  sp_q;
	logic [sipq_pkg::CNT_W-1:0]   idx_q;
	logic                         found_q;
	sipq_pkg::entry_t             carry_q;
	logic [sipq_pkg::NODE_BITS-1:0] pop_node_q;
	logic signed [31:0]           pop_cost_q;
	logic                         pop_valid_q;
	logic                         ovf_q;

	sipq_pkg::entry_t             new_entry;
	sipq_pkg::entry_t             rd_entry;
	logic [sipq_pkg::ENTRY_W-1:0] rdata;
	logic                         we;
	logic [sipq_pkg::ADDR_W-1:0]  waddr;
	sipq_pkg::entry_t             wdata;
	logic [sipq_pkg::ADDR_W-1:0]  raddr;
	logic                         take;

	assign new_entry.node = sipq_pkg::NODE_BITS'(req_q.node_id);
	assign new_entry.cost = req_q.cost;
	assign rd_entry       = sipq_pkg::entry_t'(rdata);

	// displace from the first entry whose cost is not below the new one
	assign take = found_q || !($signed(rd_entry.cost) < $signed(req_q.cost));

	always_comb begin
		we    = 1'b0;
		waddr = tail_q;
		wdata = new_entry;
		if (cmd.do_append) begin
			we = 1'b1;
		end else if ((cmd.scan_step && take) || cmd.scan_tail) begin
			we    = 1'b1;
			waddr = sp_q;
			wdata = carry_q;
		end
	end

	assign raddr = cmd.scan_step ? next_ptr(sp_q) : head_q;

	sipq_ram #(
		.WIDTH(sipq_pkg::ENTRY_W),
		.DEPTH(sipq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pop_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.latch_req) begin
				pop_valid_q <= 1'b0;
				ovf_q       <= 1'b0;
			end
			if (cmd.set_ovf) ovf_q <= 1'b1;
			if (cmd.do_append || cmd.scan_tail) begin
				tail_q  <= next_ptr(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.do_clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			if (cmd.pop_take) begin
				head_q      <= next_ptr(head_q);
				count_q     <= count_q - 1'b1;
				pop_valid_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				found_q <= 1'b0;
			end else if (cmd.scan_step && take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q      <= request;
			pop_node_q <= '0;
			pop_cost_q <= '0;
		end
		if (cmd.pop_take) begin
			pop_node_q <= rd_entry.node;
			pop_cost_q <= rd_entry.cost;
		end
		if (cmd.scan_start) begin
			sp_q    <= head_q;
			idx_q   <= '0;
			carry_q <= new_entry;
		end else if (cmd.scan_step) begin
			sp_q  <= next_ptr(sp_q);
			idx_q <= idx_q + 1'b1;
			if (take) carry_q <= rd_entry;
		end
	end

	assign st.req_type  = req_q.req_type;
	assign st.full      = (count_q == sipq_pkg::CNT_W'(sipq_pkg::QUEUE_DEPTH));
	assign st.empty     = (count_q == '0);
	assign st.scan_last = (idx_q == count_q - 1'b1);
	assign st.count     = count_q;

	assign result.pop_node_id = 16'(pop_node_q);
	assign result.pop_cost    = pop_cost_q;
	assign result.pop_valid   = pop_valid_q;
	assign result.queue_empty = (count_q == '0);
	assign result.queue_count = 7'(count_q);
	assign result.overflow    = ovf_q;

endmodule

@@ dv/sorted_insert_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core_tb
// drives append, sorted insert, pop and clear requests into the queue core
// and checks every result against a hand-written value or an in-bench model
// of the ordered queue; a short directed table comes first, then random phases
// that fill, drain and mix the queue, with random gaps between requests
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core_tb;

	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = sipq_pkg::QUEUE_DEPTH + 16;
	localparam int RANDOM_ITEMS = 1500;
	localparam int MAX_REPORTS  = 10;
	localparam int DUE_DEPTH    = 16;
	localparam int MAX_ROWS     = 32;

	// shape of the random traffic
	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	// one directed row, with a hand-written result where it is obvious
	typedef struct packed {
		sipq_pkg::request_t req;
		bit                 typed;
		sipq_pkg::result_t  res;
	} stim_row_t;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	sipq_pkg::request_t request = '0;
	logic               busy;
	logic               done;
	sipq_pkg::result_t  result;

	// hand-written expectation riding along with the current item
	bit                 typed_on  = 1'b0;
	sipq_pkg::result_t  typed_res = '0;

	// model of the stored entries, head at index 0
	logic [sipq_pkg::NODE_BITS-1:0] held_nodes [sipq_pkg::QUEUE_DEPTH];
	logic signed [31:0]             held_costs [sipq_pkg::QUEUE_DEPTH];
	int                             held_len = 0;

	// outstanding expected results, kept as a ring
	sipq_pkg::result_t results_due [DUE_DEPTH];
	int                due_rd    = 0;
	int                due_wr    = 0;
	int                due_count = 0;

	stim_row_t directed_rows [MAX_ROWS];
	int        row_count   = 0;
	int        errors      = 0;
	int        idle_cycles = 0;

	sorted_insert_priority_queue_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #2 clk = ~clk;

	// applies one request to the model queue and returns the result it gives
	function automatic sipq_pkg::result_t apply_request(sipq_pkg::request_t r);
		sipq_pkg::result_t              res;
		int                             pos;
		logic [sipq_pkg::NODE_BITS-1:0] node;
		res = '0;
		node = r.node_id[sipq_pkg::NODE_BITS-1:0];
		case (r.req_type)
			sipq_pkg::REQ_APPEND, sipq_pkg::REQ_INSERT: begin
				if (held_len >= sipq_pkg::QUEUE_DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					pos = held_len;
					if (r.req_type == sipq_pkg::REQ_INSERT) begin
						// new entry goes ahead of the first cost that is not less
						pos = 0;
						while (pos < held_len && held_costs[pos] < r.cost)
							pos++;
					end
					for (int i = held_len; i > pos; i--) begin
						held_nodes[i] = held_nodes[i-1];
						held_costs[i] = held_costs[i-1];
					end
					held_nodes[pos] = node;
					held_costs[pos] = r.cost;
					held_len++;
				end
			end
			sipq_pkg::REQ_POP: begin
				// an empty pop leaves the pop fields at zero
				if (held_len > 0) begin
					res.pop_node_id = 16'(held_nodes[0]);
					res.pop_cost    = held_costs[0];
					res.pop_valid   = 1'b1;
					for (int i = 0; i < held_len - 1; i++) begin
						held_nodes[i] = held_nodes[i+1];
						held_costs[i] = held_costs[i+1];
					end
					held_len--;
				end
			end
			default: begin
				held_len = 0;
			end
		endcase
		res.queue_empty = (held_len == 0);
		res.queue_count = 7'(held_len);
		return res;
	endfunction

	function automatic sipq_pkg::result_t mk_res(logic [15:0] node,
			logic signed [31:0] cost, logic valid, logic [6:0] count, logic ovf);
		sipq_pkg::result_t res;
		res.pop_node_id = node;
		res.pop_cost    = cost;
		res.pop_valid   = valid;
		res.queue_empty = (count == 7'd0);
		res.queue_count = count;
		res.overflow    = ovf;
		return res;
	endfunction

	function automatic stim_row_t mk_row(sipq_pkg::req_type_t op, logic [15:0] node,
			logic signed [31:0] cost, bit typed, sipq_pkg::result_t res);
		stim_row_t row;
		row.req.req_type = op;
		row.req.node_id  = node;
		row.req.cost     = cost;
		row.typed        = typed;
		row.res          = res;
		return row;
	endfunction

	task automatic add_row(stim_row_t row);
		directed_rows[row_count] = row;
		row_count++;
	endtask

	// cost mix: extremes, a narrow band around zero for ties, full range
	function automatic logic signed [31:0] pick_cost();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3, 4: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
			5: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic sipq_pkg::request_t pick_request(phase_t phase);
		sipq_pkg::request_t r;
		int                 p;
		p = $urandom_range(0, 99);
		r.node_id = 16'($urandom_range(0, 65535));
		r.cost    = pick_cost();
		case (phase)
			PH_FILL:
				r.req_type = (p < 60) ? sipq_pkg::REQ_INSERT :
					(p < 92) ? sipq_pkg::REQ_APPEND : sipq_pkg::REQ_POP;
			PH_DRAIN:
				r.req_type = (p < 80) ? sipq_pkg::REQ_POP :
					(p < 90) ? sipq_pkg::REQ_INSERT :
					(p < 98) ? sipq_pkg::REQ_APPEND : sipq_pkg::REQ_CLEAR;
			default:
				r.req_type = (p < 35) ? sipq_pkg::REQ_INSERT :
					(p < 55) ? sipq_pkg::REQ_APPEND :
					(p < 97) ? sipq_pkg::REQ_POP : sipq_pkg::REQ_CLEAR;
		endcase
		return r;
	endfunction

	// presents one item from a falling edge and holds it until it is taken;
	// start is touched at most once per falling edge
	task automatic send_item(sipq_pkg::request_t r, bit typed,
			sipq_pkg::result_t tres, int gap, bit drain);
		if (gap > 0 || (drain && due_count != 0)) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			// hold off until every outstanding result has come back
			while (drain && due_count != 0)
				@(negedge clk);
		end
		start     <= 1'b1;
		request   <= r;
		typed_on  <= typed;
		typed_res <= tres;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
	endtask

	// result checker, model update on acceptance, and stall watchdog
	always @(posedge clk) begin
		sipq_pkg::result_t want;
		if (done) begin
			if (due_count == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result with nothing outstanding: node %h cost %0d valid %b",
						result.pop_node_id, result.pop_cost, result.pop_valid);
			end else begin
				want = results_due[due_rd];
				due_rd = (due_rd + 1) % DUE_DEPTH;
				due_count--;
				if (result.pop_node_id !== want.pop_node_id ||
						result.pop_cost !== want.pop_cost ||
						result.pop_valid !== want.pop_valid ||
						result.queue_empty !== want.queue_empty ||
						result.queue_count !== want.queue_count ||
						result.overflow !== want.overflow) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("mismatch exp: node %h cost %0d valid %b empty %b count %0d ovf %b",
							want.pop_node_id, want.pop_cost, want.pop_valid,
							want.queue_empty, want.queue_count, want.overflow);
						$display("         got: node %h cost %0d valid %b empty %b count %0d ovf %b",
							result.pop_node_id, result.pop_cost, result.pop_valid,
							result.queue_empty, result.queue_count, result.overflow);
					end
				end
			end
		end
		// item taken at this edge: step the model in acceptance order
		if (arst_n && start && !busy) begin
			want = apply_request(request);
			if (due_count == DUE_DEPTH) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("too many items accepted without a result");
			end else begin
				results_due[due_wr] = typed_on ? typed_res : want;
				due_wr = (due_wr + 1) % DUE_DEPTH;
				due_count++;
			end
		end
		// watchdog on cycles where nothing moves in either direction
		if (done || (start && !busy))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("sorted_insert_priority_queue_core test failed");
			$finish;
		end
	end

	initial begin
		sipq_pkg::request_t r;
		phase_t             phase;
		int                 sent;
		int                 span;
		bit                 no_idle;
		int                 gap;
		bit                 drain;

		// directed table: empty queue, extremes, ties, every request kind
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd0, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_CLEAR, 16'hffff, -32'sd1, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd0, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_APPEND, 16'hffff, 32'sh7fff_ffff, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd1, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_INSERT, 16'h0000, 32'sh8000_0000, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd2, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h1234, 32'sd9, 1,
			mk_res(16'h0000, 32'sh8000_0000, 1'b1, 7'd1, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 1,
			mk_res(16'hffff, 32'sh7fff_ffff, 1'b1, 7'd0, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd0, 1'b0)));
		// equal costs: the newer insert must land ahead of the older one
		add_row(mk_row(sipq_pkg::REQ_INSERT, 16'h0001, 32'sd5, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_INSERT, 16'h0002, 32'sd5, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_APPEND, 16'h0003, -32'sd7, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_INSERT, 16'h0004, -32'sd1, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_INSERT, 16'h0005, 32'sd100, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_INSERT, 16'haaaa, 32'sh5555_5555, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_APPEND, 16'h5555, 32'shaaaa_aaaa, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 0, '0));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 0, '0));
		// clear of a populated queue, then nothing left to pop
		add_row(mk_row(sipq_pkg::REQ_CLEAR, 16'h0000, 32'sd0, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd0, 1'b0)));
		add_row(mk_row(sipq_pkg::REQ_POP, 16'h0000, 32'sd0, 1,
			mk_res(16'h0000, 32'sd0, 1'b0, 7'd0, 1'b0)));

		// reset held low from the start, released on a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < row_count; i++)
			send_item(directed_rows[i].req, directed_rows[i].typed,
				directed_rows[i].res, $urandom_range(0, 10), 1'b0);

		// random part: the first phase always overfills the queue
		sent  = 0;
		phase = PH_FILL;
		span  = sipq_pkg::QUEUE_DEPTH + 20;
		no_idle = 1'b0;
		drain = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
				r = pick_request(phase);
				// the opening phase has no pops so the overflow path is reached
				if (sent < sipq_pkg::QUEUE_DEPTH + 20 && r.req_type == sipq_pkg::REQ_POP)
					r.req_type = sipq_pkg::REQ_INSERT;
				gap = no_idle ? 0 : $urandom_range(0, 10);
				send_item(r, 1'b0, '0, gap, drain);
				drain = 1'b0;
				sent++;
				// periodic full drain of outstanding results
				if (sent % 250 == 0)
					drain = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: phase = PH_FILL;
				3, 4: phase = PH_DRAIN;
				default: phase = PH_MIX;
			endcase
			span    = $urandom_range(20, 90);
			no_idle = ($urandom_range(0, 3) == 0);
		end

		start <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		// extra cycles to catch any stray result
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && due_count == 0)
			$display("sorted_insert_priority_queue_core test passed");
		else
			$display("sorted_insert_priority_queue_core test failed");
		$finish;
	end

endmodule
